[src/serial_command_frame_responder_assert.svh]
// Assertion macros shared by the responder modules
`ifndef SERIAL_COMMAND_FRAME_RESPONDER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_RESPONDER_ASSERT_SVH

`ifndef SYNTH
`define SCFR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
`define SCFR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define SCFR_ASSERT_IMP(lbl, ante, cons)
`define SCFR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[src/scfr_pkg.sv]
package scfr_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int IDX_W       = $clog2(MAX_PAYLOAD + 4);

	localparam logic [7:0] MARKER_RESET = 8'h7F;
	localparam logic [7:0] REQ_PING     = 8'h00;
	localparam logic [7:0] REQ_VERSION  = 8'h01;
	localparam logic [7:0] REQ_ECHO     = 8'h03;
	localparam logic [7:0] ANS_SHORT    = 8'h81;
	localparam logic [7:0] ANS_ECHO     = 8'h82;
	localparam int PONG_LEN             = 4;
	localparam int VERSION_LEN          = 3;

	typedef struct packed {
		logic take_cmd;
		logic take_len;
		logic take_data;
		logic start_reply;
		logic fetch;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic marker_hit;
		logic len_zero;
		logic data_done;
		logic reply_go;
		logic slot_free;
		logic last_byte;
	} dp_status_t;

	function automatic logic [7:0] short_text(input logic version, input logic [1:0] k);
		logic [7:0] b;
		b = 8'h00;
		if (version) begin
			case (k)
				2'd0: b = 8'h30;
				2'd1: b = 8'h2E;
				2'd2: b = 8'h31;
				default: b = 8'h00;
			endcase
		end else begin
			case (k)
				2'd0: b = 8'h50;
				2'd1: b = 8'h4F;
				2'd2: b = 8'h4E;
				default: b = 8'h47;
			endcase
		end
		return b;
	endfunction

endpackage

[src/scfr_if.sv]
interface scfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfr_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       frame_end;
	modport source (output valid, output tx_byte, output frame_end, input ready);
	modport sink (input valid, input tx_byte, input frame_end, output ready);
endinterface

interface scfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] start_marker;
	modport source (output valid, output start_marker, input ready);
	modport sink (input valid, input start_marker, output ready);
endinterface

[src/scfr_ram.sv]
module scfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/scfr_dp.sv]
`include "serial_command_frame_responder_assert.svh"

module scfr_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scfr_pkg::dp_cmd_t    cmd,
	output scfr_pkg::dp_status_t status,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           tx_byte,
	output logic                 frame_end
);

	logic [7:0]                 marker_q;
	logic [7:0]                 cmd_q;
	logic [7:0]                 len_q;
	logic [scfr_pkg::CNT_W-1:0] cnt_q;
	logic [7:0]                 xor_q;
	logic                       ovf_q;
	logic                       is_echo_q;
	logic                       is_version_q;
	logic [scfr_pkg::CNT_W-1:0] rlen_q;
	logic [scfr_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                 tx_sum_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       out_end_q;

	logic [scfr_pkg::CNT_W-1:0]  cnt_next;
	logic [scfr_pkg::IDX_W-1:0]  last_idx;
	logic [scfr_pkg::IDX_W-1:0]  data_idx;
	logic [scfr_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0]                  ram_rdata;
	logic [7:0]                  sel_byte;
	logic                        is_last;
	logic                        known_cmd;

	assign cnt_next  = cnt_q + scfr_pkg::CNT_W'(1);
	assign last_idx  = scfr_pkg::IDX_W'(rlen_q) + scfr_pkg::IDX_W'(3);
	assign data_idx  = idx_q - scfr_pkg::IDX_W'(3);
	assign rd_addr   = data_idx[scfr_pkg::ADDR_W-1:0];
	assign is_last   = (idx_q == last_idx);
	assign known_cmd = (cmd_q == scfr_pkg::REQ_PING) || (cmd_q == scfr_pkg::REQ_VERSION)
		|| (cmd_q == scfr_pkg::REQ_ECHO);

	scfr_ram #(
		.WIDTH(8),
		.DEPTH(scfr_pkg::MAX_PAYLOAD)
	) u_store (
		.clk  (clk),
		.we   (cmd.take_data),
		.waddr(cnt_q[scfr_pkg::ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (cmd.fetch),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (idx_q == scfr_pkg::IDX_W'(0)) begin
			sel_byte = marker_q;
		end else if (idx_q == scfr_pkg::IDX_W'(1)) begin
			sel_byte = is_echo_q ? scfr_pkg::ANS_ECHO : scfr_pkg::ANS_SHORT;
		end else if (idx_q == scfr_pkg::IDX_W'(2)) begin
			sel_byte = 8'(rlen_q);
		end else if (is_last) begin
			sel_byte = tx_sum_q;
		end else if (is_echo_q) begin
			sel_byte = ram_rdata;
		end else begin
			sel_byte = scfr_pkg::short_text(is_version_q, data_idx[1:0]);
		end
	end

	always_comb begin
		status.marker_hit = (rx_byte == marker_q);
		status.len_zero   = (rx_byte == 8'h00);
		status.data_done  = (cnt_next >= scfr_pkg::CNT_W'(scfr_pkg::MAX_PAYLOAD))
			|| (8'(cnt_next) == len_q);
		status.reply_go   = !ovf_q && (rx_byte == xor_q) && known_cmd;
		status.slot_free  = !out_valid_q || out_ready;
		status.last_byte  = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q    <= scfr_pkg::MARKER_RESET;
			cmd_q       <= 8'h00;
			len_q       <= 8'h00;
			cnt_q       <= '0;
			xor_q       <= 8'h00;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				marker_q <= cfg_data;
			end
			if (cmd.take_cmd) begin
				cmd_q <= rx_byte;
				xor_q <= rx_byte;
			end
			if (cmd.take_len) begin
				len_q <= rx_byte;
				xor_q <= xor_q ^ rx_byte;
				cnt_q <= '0;
				ovf_q <= (rx_byte > 8'(scfr_pkg::MAX_PAYLOAD));
			end
			if (cmd.take_data) begin
				xor_q <= xor_q ^ rx_byte;
				cnt_q <= cnt_next;
			end
			if (cmd.start_reply) begin
				idx_q <= '0;
			end else if (cmd.load) begin
				idx_q <= idx_q + scfr_pkg::IDX_W'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_reply) begin
			is_echo_q    <= (cmd_q == scfr_pkg::REQ_ECHO);
			is_version_q <= (cmd_q == scfr_pkg::REQ_VERSION);
			tx_sum_q     <= 8'h00;
			if (cmd_q == scfr_pkg::REQ_PING) begin
				rlen_q <= scfr_pkg::CNT_W'(scfr_pkg::PONG_LEN);
			end else if (cmd_q == scfr_pkg::REQ_VERSION) begin
				rlen_q <= scfr_pkg::CNT_W'(scfr_pkg::VERSION_LEN);
			end else begin
				rlen_q <= len_q[scfr_pkg::CNT_W-1:0];
			end
		end else if (cmd.load) begin
			if (idx_q != scfr_pkg::IDX_W'(0) && !is_last) begin
				tx_sum_q <= tx_sum_q ^ sel_byte;
			end
		end
		if (cmd.load) begin
			out_byte_q <= sel_byte;
			out_end_q  <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte   = out_byte_q;
	assign frame_end = out_end_q;

	`SCFR_ASSERT_IMP(a_no_overwrite, cmd.load, !out_valid_q || out_ready)
	`SCFR_ASSERT_IMP(a_store_bound, cmd.take_data, cnt_q < scfr_pkg::CNT_W'(scfr_pkg::MAX_PAYLOAD))
	`SCFR_ASSERT_IMP(a_idx_bound, cmd.load, idx_q <= last_idx)
	`SCFR_ASSERT_NXT(a_reply_len, cmd.start_reply, rlen_q <= scfr_pkg::CNT_W'(scfr_pkg::MAX_PAYLOAD))

endmodule

[src/scfr_ctrl.sv]
`include "serial_command_frame_responder_assert.svh"

module scfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  scfr_pkg::dp_status_t status,
	output scfr_pkg::dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_START,
		ST_CMD,
		ST_LEN,
		ST_DATA,
		ST_CHK,
		ST_FETCH,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   acc;

	always_comb begin
		in_ready = (state_q == ST_START) || (state_q == ST_CMD) || (state_q == ST_LEN)
			|| (state_q == ST_DATA) || (state_q == ST_CHK);
		acc             = in_valid && in_ready;
		cmd.take_cmd    = acc && (state_q == ST_CMD);
		cmd.take_len    = acc && (state_q == ST_LEN);
		cmd.take_data   = acc && (state_q == ST_DATA);
		cmd.start_reply = acc && (state_q == ST_CHK) && status.reply_go;
		cmd.fetch       = (state_q == ST_FETCH);
		cmd.load        = (state_q == ST_LOAD) && status.slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
		end else begin
			case (state_q)
				ST_START: begin
					if (acc && status.marker_hit) begin
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					if (acc) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (acc) begin
						state_q <= status.len_zero ? ST_CHK : ST_DATA;
					end
				end
				ST_DATA: begin
					if (acc && status.data_done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (acc) begin
						state_q <= status.reply_go ? ST_FETCH : ST_START;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (status.slot_free) begin
						state_q <= status.last_byte ? ST_START : ST_FETCH;
					end
				end
				default: begin
					state_q <= ST_START;
				end
			endcase
		end
	end

	`SCFR_ASSERT_NXT(a_reply_fetch, cmd.start_reply, state_q == ST_FETCH)
	`SCFR_ASSERT_IMP(a_no_rx_in_reply, cmd.fetch || cmd.load, !in_ready)
	`SCFR_ASSERT_NXT(a_fetch_load, cmd.fetch, state_q == ST_LOAD)

endmodule

[src/serial_command_frame_responder.sv]
// Serial command frame responder. Received bytes are taken on rx, one per cycle while
// the block is receiving: start marker, command, length, data and checksum. A frame with
// a length of at most 32, a good checksum and a ping, version or echo command is
// answered on tx with start marker, code, length, data and checksum, frame_end marking
// the checksum byte. Replies are 8 bytes (ping), 7 bytes (version) or length + 4 bytes
// (echo). While a reply is built rx is held off; each reply byte passes a FETCH state
// that reads the payload RAM (registered read) and a LOAD state that loads the output
// register and waits while tx stalls. The start marker is written on cfg (reset 0x7F)
// and cfg is always ready. There is no clearing pass.
module serial_command_frame_responder (
	input logic        clk,
	input logic        arst_n,
	scfr_rx_if.sink    rx,
	scfr_tx_if.source  tx,
	scfr_cfg_if.sink   cfg
);

	scfr_pkg::dp_cmd_t    cmd;
	scfr_pkg::dp_status_t status;
	logic                 rx_ready;

	assign rx.ready  = rx_ready;
	assign cfg.ready = 1'b1;

	scfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(rx.valid),
		.in_ready(rx_ready),
		.status  (status),
		.cmd     (cmd)
	);

	scfr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.rx_byte  (rx.rx_byte),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.start_marker),
		.out_valid(tx.valid),
		.out_ready(tx.ready),
		.tx_byte  (tx.tx_byte),
		.frame_end(tx.frame_end)
	);

endmodule

[tb/serial_command_frame_responder_test.sv]
`timescale 1ns / 1ps

module serial_command_frame_responder_test;

	localparam logic [7:0]  REQ_TIME     = 8'h02;
	localparam logic [31:0] PONG_TEXT    = 32'h504F4E47;
	localparam logic [23:0] VERSION_TEXT = 24'h302E31;
	localparam int          ERR_PRINT    = 50;
	localparam int          SETTLE       = 40;

	typedef enum logic [2:0] {
		PH_AWAIT,
		PH_CMD,
		PH_LEN,
		PH_DATA,
		PH_CHK
	} rx_phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} reply_byte_t;

	class reply_scoreboard_t;
		logic [7:0]  marker;
		rx_phase_t   rx_phase;
		logic [7:0]  command;
		logic [7:0]  length;
		logic [5:0]  count;
		logic [7:0]  run_xor;
		logic        overflow;
		logic [7:0]  store [scfr_pkg::MAX_PAYLOAD];
		logic [7:0]  body [scfr_pkg::MAX_PAYLOAD];
		reply_byte_t pending[$];
		int          errors;
		int          bytes_checked;
		int          frames_checked;

		function new();
			marker = scfr_pkg::MARKER_RESET;
			rx_phase = PH_AWAIT;
			command = 8'h00;
			length = 8'h00;
			count = 6'd0;
			run_xor = 8'h00;
			overflow = 1'b0;
			errors = 0;
			bytes_checked = 0;
			frames_checked = 0;
		endfunction

		function void set_marker(logic [7:0] m);
			marker = m;
		endfunction

		function void emit(logic [7:0] b, logic last);
			reply_byte_t r;
			r.data = b;
			r.last = last;
			pending.push_back(r);
		endfunction

		function void emit_frame(logic [7:0] code, int len);
			logic [7:0] sum;
			sum = code ^ 8'(len);
			emit(marker, 1'b0);
			emit(code, 1'b0);
			emit(8'(len), 1'b0);
			for (int i = 0; i < len; i++) begin
				emit(body[i], 1'b0);
				sum ^= body[i];
			end
			emit(sum, 1'b1);
		endfunction

		function void note_rx(logic [7:0] b);
			case (rx_phase)
				PH_CMD: begin
					command = b;
					run_xor = b;
					rx_phase = PH_LEN;
				end
				PH_LEN: begin
					length = b;
					run_xor ^= b;
					count = 6'd0;
					overflow = (b > scfr_pkg::MAX_PAYLOAD);
					rx_phase = (b != 8'h00) ? PH_DATA : PH_CHK;
				end
				PH_DATA: begin
					if (count < scfr_pkg::MAX_PAYLOAD)
						store[count] = b;
					run_xor ^= b;
					count = count + 6'd1;
					if (count >= scfr_pkg::MAX_PAYLOAD || {2'b00, count} == length)
						rx_phase = PH_CHK;
				end
				PH_CHK: begin
					rx_phase = PH_AWAIT;
					if (!overflow && b == run_xor) begin
						if (command == scfr_pkg::REQ_PING) begin
							for (int i = 0; i < scfr_pkg::PONG_LEN; i++)
								body[i] = PONG_TEXT[31 - 8 * i -: 8];
							emit_frame(scfr_pkg::ANS_SHORT, scfr_pkg::PONG_LEN);
						end else if (command == scfr_pkg::REQ_VERSION) begin
							for (int i = 0; i < scfr_pkg::VERSION_LEN; i++)
								body[i] = VERSION_TEXT[23 - 8 * i -: 8];
							emit_frame(scfr_pkg::ANS_SHORT, scfr_pkg::VERSION_LEN);
						end else if (command == scfr_pkg::REQ_ECHO) begin
							for (int i = 0; i < length; i++)
								body[i] = store[i];
							emit_frame(scfr_pkg::ANS_ECHO, length);
						end
					end
				end
				default: begin
					rx_phase = (b == marker) ? PH_CMD : PH_AWAIT;
				end
			endcase
		endfunction

		task report(string what, logic [8:0] got, logic [8:0] want);
			errors++;
			if (errors <= ERR_PRINT)
				$display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
		endtask

		task check_tx(logic [7:0] b, logic last);
			reply_byte_t r;
			bytes_checked++;
			if (pending.size() == 0) begin
				report("unexpected tx byte", {1'b0, b}, 9'h000);
			end else begin
				r = pending.pop_front();
				if (b !== r.data)
					report("tx_byte", {1'b0, b}, {1'b0, r.data});
				if (last !== r.last)
					report("frame_end", {8'h00, last}, {8'h00, r.last});
				if (r.last)
					frames_checked++;
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	scfr_rx_if  rx_ch ();
	scfr_tx_if  tx_ch ();
	scfr_cfg_if cfg_ch ();

	serial_command_frame_responder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch),
		.cfg    (cfg_ch)
	);

	reply_scoreboard_t sb;
	logic [7:0]        cur_marker;
	int unsigned       burst_left;
	int                item_count;
	int                request_count;
	int                marker_writes;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("serial_command_frame_responder_test: FAIL");
		$finish;
	end

	// send one byte; bursts with random gaps between them
	task automatic push_rx(input logic [7:0] b);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(30, 60);
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
			end
		end
		@(negedge clk);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		burst_left--;
		sb.note_rx(b);
	endtask

	task automatic send_request(input logic [7:0] cmd, input int unsigned len,
			input bit corrupt, input bit extreme);
		logic [7:0]  sum;
		logic [7:0]  d;
		int unsigned n;
		n = (len > scfr_pkg::MAX_PAYLOAD) ? scfr_pkg::MAX_PAYLOAD : len;
		push_rx(cur_marker);
		push_rx(cmd);
		push_rx(8'(len));
		sum = cmd ^ 8'(len);
		for (int unsigned i = 0; i < n; i++) begin
			d = extreme ? (i[0] ? 8'h00 : 8'hFF) : 8'($urandom);
			push_rx(d);
			sum ^= d;
		end
		if (corrupt)
			sum ^= 8'($urandom_range(1, 255));
		push_rx(sum);
		item_count += n + 4;
		request_count++;
	endtask

	task automatic send_noise(input int unsigned n);
		logic [7:0] b;
		for (int unsigned i = 0; i < n; i++) begin
			b = 8'($urandom);
			if (b == cur_marker)
				b = ~b;
			push_rx(b);
			item_count++;
		end
	endtask

	// advance the receiver back to hunting for the marker
	task automatic resync();
		while (sb.rx_phase != PH_AWAIT) begin
			push_rx(8'($urandom));
			item_count++;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_marker(input logic [7:0] m);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.start_marker <= m;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.set_marker(m);
		cur_marker = m;
		marker_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_command();
		int unsigned r;
		logic [7:0]  c;
		r = $urandom_range(0, 9);
		if (r < 2)
			c = scfr_pkg::REQ_PING;
		else if (r < 4)
			c = scfr_pkg::REQ_VERSION;
		else if (r < 7)
			c = scfr_pkg::REQ_ECHO;
		else if (r < 8)
			c = REQ_TIME;
		else
			c = 8'($urandom);
		return c;
	endfunction

	function automatic int unsigned pick_length();
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		if (r < 60)
			n = $urandom_range(0, 6);
		else if (r < 75)
			n = $urandom_range(7, scfr_pkg::MAX_PAYLOAD - 1);
		else if (r < 85)
			n = scfr_pkg::MAX_PAYLOAD;
		else if (r < 95)
			n = $urandom_range(scfr_pkg::MAX_PAYLOAD + 1, 255);
		else
			n = 0;
		return n;
	endfunction

	task automatic random_phase(input int target);
		int          start_items;
		int unsigned r;
		int unsigned n;
		logic [7:0]  c;
		start_items = item_count;
		send_request(scfr_pkg::REQ_ECHO, scfr_pkg::MAX_PAYLOAD, 1'b0, 1'b0);
		send_request(scfr_pkg::REQ_ECHO, $urandom_range(scfr_pkg::MAX_PAYLOAD + 1, 255),
			1'b0, 1'b0);
		while (item_count - start_items < target) begin
			r = $urandom_range(0, 99);
			c = pick_command();
			n = pick_length();
			if (r < 70) begin
				send_request(c, n, 1'b0, 1'b0);
			end else if (r < 82) begin
				send_request(c, n, 1'b1, 1'b0);
			end else if (r < 90) begin
				send_noise($urandom_range(1, 5));
				send_request(c, n, 1'b0, 1'b0);
			end else begin
				// drop a frame part way through
				push_rx(cur_marker);
				push_rx(c);
				item_count += 2;
				if ($urandom_range(0, 1)) begin
					push_rx(8'(n));
					item_count++;
					for (int unsigned i = 0; i < $urandom_range(0, 3); i++) begin
						push_rx(8'($urandom));
						item_count++;
					end
				end
				resync();
			end
		end
	endtask

	// receiver with a stall pattern whose mode is picked anew at random
	initial begin
		int          cyc;
		int          mode;
		int unsigned stall_left;
		logic        rdy;
		cyc = 0;
		mode = 0;
		stall_left = 0;
		tx_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1)
				sb.check_tx(tx_ch.tx_byte, tx_ch.frame_end);
			@(negedge clk);
			cyc++;
			if (cyc % 50 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom);
				2: rdy = (cyc % 4 != 0);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						rdy = 1'b0;
					end else if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(2, 12);
						rdy = 1'b0;
					end else begin
						rdy = 1'b1;
					end
				end
			endcase
			tx_ch.ready <= rdy;
		end
	end

	initial begin
		sb = new();
		cur_marker = scfr_pkg::MARKER_RESET;
		burst_left = 0;
		item_count = 0;
		request_count = 0;
		marker_writes = 0;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.start_marker = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(scfr_pkg::REQ_PING, 0, 1'b0, 1'b0);
		send_request(scfr_pkg::REQ_VERSION, 0, 1'b0, 1'b0);
		send_request(scfr_pkg::REQ_ECHO, 0, 1'b0, 1'b0);
		send_request(scfr_pkg::REQ_ECHO, 3, 1'b0, 1'b1);
		send_request(REQ_TIME, 0, 1'b0, 1'b0);
		send_request(scfr_pkg::REQ_PING, 1, 1'b1, 1'b0);
		drain();

		write_marker(8'h00);
		random_phase(90);
		drain();
		write_marker(8'hFF);
		random_phase(90);
		drain();
		write_marker(8'($urandom));
		random_phase(90);
		drain();
		write_marker(scfr_pkg::MARKER_RESET);
		random_phase(90);
		drain();

		if (sb.pending.size() != 0)
			sb.report("reply bytes never sent", 9'(sb.pending.size()), 9'h000);
		$display("covered %0d requests over %0d frame bytes with %0d marker settings",
			request_count, item_count, marker_writes);
		$display("checked %0d reply bytes in %0d reply frames, %0d mismatches",
			sb.bytes_checked, sb.frames_checked, sb.errors);
		if (sb.errors == 0)
			$display("serial_command_frame_responder_test: PASS");
		else
			$display("serial_command_frame_responder_test: FAIL");
		$finish;
	end

endmodule
